[hdl/cal_pkg.sv]
`timescale 1ns / 1ps
package cal_pkg;

    localparam int unsigned ADDR_W  = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned PLEN_W  = 8;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    localparam logic FAM_V4 = 1'b0;
    localparam logic FAM_V6 = 1'b1;

    localparam logic [PLEN_W-1:0] V4_MAX_PLEN = 8'd32;
    localparam logic [PLEN_W-1:0] V6_MAX_PLEN = 8'd128;

    // register select is paddr bit 2 (byte address 4*i)
    localparam logic REG_DENY_FIRST = 1'b0;
    localparam logic REG_RULE_COUNT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              family;
        logic [PLEN_W-1:0] prefix_length;
        logic [ADDR_W-1:0] addr;
    } t_rule;

    typedef struct packed {
        logic               deny_first;
        logic [COUNT_W-1:0] rule_count;
    } t_cfg;

endpackage

[hdl/cal_in_if.sv]
`timescale 1ns / 1ps
interface cal_in_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [cal_pkg::SLOT_W-1:0]          rule_index;
    logic                                family;
    logic [cal_pkg::PLEN_W-1:0]          prefix_length;
    logic [cal_pkg::HALF_W-1:0]          addr_high;
    logic [cal_pkg::HALF_W-1:0]          addr_low;

    modport source (
        output valid, action, rule_index, family, prefix_length, addr_high, addr_low,
        input  ready
    );
    modport sink (
        input  valid, action, rule_index, family, prefix_length, addr_high, addr_low,
        output ready
    );
    modport monitor (
        input valid, ready, action, rule_index, family, prefix_length, addr_high, addr_low
    );
endinterface

[hdl/cal_out_if.sv]
`timescale 1ns / 1ps
interface cal_out_if;
    logic valid;
    logic ready;
    logic accepted;
    logic matched;

    modport source (
        output valid, accepted, matched,
        input  ready
    );
    modport sink (
        input  valid, accepted, matched,
        output ready
    );
    modport monitor (
        input valid, ready, accepted, matched
    );
endinterface

[hdl/cal_rule_mem.sv]
`timescale 1ns / 1ps
module cal_rule_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned IDX_W = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  cal_pkg::t_rule    i_wr_data,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output cal_pkg::t_rule    o_rd_data
);

    cal_pkg::t_rule r_mem [DEPTH];
    cal_pkg::t_rule r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hdl/cal_prefix_match.sv]
`timescale 1ns / 1ps
module cal_prefix_match (
    input  cal_pkg::t_rule                  i_rule,
    input  logic                            i_family,
    input  logic [cal_pkg::ADDR_W-1:0]      i_addr,
    output logic                            o_hit
);

    logic [cal_pkg::PLEN_W-1:0] plen;
    logic [cal_pkg::ADDR_W-1:0] mask;

    always_comb begin
        if (i_rule.family == cal_pkg::FAM_V4) begin
            plen = (i_rule.prefix_length > cal_pkg::V4_MAX_PLEN) ?
                   cal_pkg::V4_MAX_PLEN : i_rule.prefix_length;
        end else begin
            plen = (i_rule.prefix_length > cal_pkg::V6_MAX_PLEN) ?
                   cal_pkg::V6_MAX_PLEN : i_rule.prefix_length;
        end
        // leading-ones mask, msb first
        for (int j = 0; j < int'(cal_pkg::ADDR_W); j++) begin
            mask[int'(cal_pkg::ADDR_W) - 1 - j] = (cal_pkg::PLEN_W'(j) < plen);
        end
        o_hit = (i_rule.family == i_family) && (((i_rule.addr ^ i_addr) & mask) == '0);
    end

endmodule

[hdl/cal_apb_regs.sv]
`timescale 1ns / 1ps
module cal_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cal_pkg::PADDR_W-1:0]   paddr,
    input  logic [cal_pkg::PDATA_W-1:0]   pwdata,
    output logic [cal_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output cal_pkg::t_cfg                 o_cfg
);

    cal_pkg::t_cfg r_cfg;
    logic          wr_xfer;
    logic          reg_sel;

    assign pready  = 1'b1;
    assign wr_xfer = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_xfer) begin
            case (reg_sel)
                cal_pkg::REG_DENY_FIRST: r_cfg.deny_first <= pwdata[0];
                cal_pkg::REG_RULE_COUNT: r_cfg.rule_count <= pwdata[cal_pkg::COUNT_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            cal_pkg::REG_DENY_FIRST:
                prdata = {{(cal_pkg::PDATA_W-1){1'b0}}, r_cfg.deny_first};
            cal_pkg::REG_RULE_COUNT:
                prdata = {{(cal_pkg::PDATA_W-cal_pkg::COUNT_W){1'b0}}, r_cfg.rule_count};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/cidr_access_list_check.sv]
`timescale 1ns / 1ps
// a rule write is written at its transfer and ready stays high, so writes can follow back to back
// a check gives its result once the walk over rules 0 to n - 1 is done, n = min(rule_count, RULES),
// or without a walk when n is zero; a match at rule k ends the walk early
// one rule-table read and one prefix compare per cycle; ready is low until the result loads
// a finished check waits while an earlier result is still stalled at the output
// synchronous active-low reset clears state, walk, output-valid and config registers, not the rule table
module cidr_access_list_check #(
    parameter int unsigned RULES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    cal_in_if.sink                        i_in,
    cal_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cal_pkg::PADDR_W-1:0]   paddr,
    input  logic [cal_pkg::PDATA_W-1:0]   pwdata,
    output logic [cal_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int unsigned IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
    localparam int unsigned CNT_W = $clog2(RULES + 1);

    cal_pkg::t_cfg   cfg;
    cal_pkg::t_state r_state, n_state;
    cal_pkg::t_rule  wr_rule;
    cal_pkg::t_rule  rd_rule;

    logic [CNT_W-1:0]           r_idx, n_idx;
    logic [CNT_W-1:0]           r_n;
    logic [CNT_W-1:0]           cnt_clamped;
    logic                       r_dvld, n_dvld;
    logic                       r_last, n_last;
    logic                       r_hit, n_hit;
    logic                       r_fam;
    logic [cal_pkg::ADDR_W-1:0] r_key;
    logic                       r_out_vld, n_out_vld;
    logic                       r_out_acc, n_out_acc;
    logic                       r_out_match, n_out_match;

    logic in_xfer;
    logic start;
    logic wr_en;
    logic rd_en;
    logic hit_w;

    cal_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_in.ready = (r_state == cal_pkg::S_IDLE);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign start      = in_xfer && (i_in.action == cal_pkg::ACT_CHECK);
    assign wr_en      = in_xfer && (i_in.action == cal_pkg::ACT_WRITE) &&
                        ({28'd0, i_in.rule_index} < 32'(RULES));

    assign wr_rule.family        = i_in.family;
    assign wr_rule.prefix_length = i_in.prefix_length;
    assign wr_rule.addr          = {i_in.addr_high, i_in.addr_low};

    assign cnt_clamped = ({27'd0, cfg.rule_count} > 32'(RULES)) ?
                         CNT_W'(RULES) : CNT_W'(cfg.rule_count);

    cal_rule_mem #(
        .DEPTH (RULES),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(i_in.rule_index)),
        .i_wr_data (wr_rule),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_rule)
    );

    cal_prefix_match u_match (
        .i_rule   (rd_rule),
        .i_family (r_fam),
        .i_addr   (r_key),
        .o_hit    (hit_w)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cal_pkg::S_IDLE;
            r_idx       <= '0;
            r_dvld      <= 1'b0;
            r_last      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_dvld      <= n_dvld;
            r_last      <= n_last;
            r_hit       <= n_hit;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_acc   <= n_out_acc;
        r_out_match <= n_out_match;
        if (start) begin
            r_fam <= i_in.family;
            r_key <= {i_in.addr_high, i_in.addr_low};
            r_n   <= cnt_clamped;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_dvld      = 1'b0;
        n_last      = r_last;
        n_hit       = r_hit;
        n_out_vld   = r_out_vld && !o_out.ready;
        n_out_acc   = r_out_acc;
        n_out_match = r_out_match;
        rd_en       = 1'b0;
        case (r_state)
            cal_pkg::S_IDLE: begin
                if (start) begin
                    n_idx   = '0;
                    n_hit   = 1'b0;
                    n_state = (cnt_clamped == '0) ? cal_pkg::S_FIN : cal_pkg::S_SCAN;
                end
            end
            cal_pkg::S_SCAN: begin
                // read rule r_idx while comparing the one read last cycle
                if (r_idx < r_n) begin
                    rd_en  = 1'b1;
                    n_dvld = 1'b1;
                    n_last = (r_idx == (r_n - CNT_W'(1)));
                    n_idx  = r_idx + CNT_W'(1);
                end
                if (r_dvld && (hit_w || r_last)) begin
                    n_hit   = hit_w;
                    n_state = cal_pkg::S_FIN;
                end
            end
            cal_pkg::S_FIN: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld   = 1'b1;
                    n_out_acc   = r_hit ? cfg.deny_first : !cfg.deny_first;
                    n_out_match = r_hit;
                    n_state     = cal_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cal_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out.valid    = r_out_vld;
    assign o_out.accepted = r_out_acc;
    assign o_out.matched  = r_out_match;

endmodule

[hdl/cal_checker.sv]
`timescale 1ns / 1ps
module cal_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    cal_in_if.sink      i_in,
    cal_out_if.source   o_out
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (i_in.ready && !o_out.valid))
        else $error("ready or result wrong after reset");

    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.action == cal_pkg::ACT_CHECK)) |=> !i_in.ready)
        else $error("ready high right after a check transfer");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && (i_in.action == cal_pkg::ACT_WRITE) && !o_out.valid)
        |=> !o_out.valid)
        else $error("result produced by a rule write");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=>
        (o_out.valid && $stable(o_out.accepted) && $stable(o_out.matched)))
        else $error("stalled result changed");

endmodule

bind cidr_access_list_check cal_checker u_cal_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);
